### hdl/pss_pkg.sv
package pss_pkg;

  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned LENGTH_BITS = 16;

  localparam int unsigned UNIT_BITS   = 16;
  localparam int unsigned OFS_BITS    = 32;
  localparam int unsigned RLEN_BITS   = 16;
  localparam int unsigned MINLEN_BITS = 16;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [7:0] BYTE_LOW  = 8'd32;
  localparam logic [7:0] BYTE_HIGH = 8'd126;
  localparam logic [7:0] BYTE_LF   = 8'd10;
  localparam logic [7:0] BYTE_CR   = 8'd13;
  localparam logic [7:0] BYTE_TAB  = 8'd9;
  localparam logic [UNIT_BITS-1:0] WIDE_LOW  = 16'd32;
  localparam logic [UNIT_BITS-1:0] WIDE_HIGH = 16'hFEFF;

  localparam logic [MINLEN_BITS-1:0] MIN_LENGTH_RESET = 16'd4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_LENGTH = 1'b0,
    CFG_WIDE_MODE  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [UNIT_BITS-1:0] unit;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic [OFS_BITS-1:0]  start_offset;
    logic [RLEN_BITS-1:0] run_length;
    logic                 is_wide;
  } out_item_t;

  typedef struct packed {
    logic [MINLEN_BITS-1:0] min_length;
    logic                   wide_mode;
  } cfg_t;

  // classification of one unit
  typedef struct packed {
    logic extend;
    logic ends;
  } unit_class_t;

endpackage

### hdl/pss_chan_if.sv
interface pss_in_if;
  logic               valid;
  logic               ready;
  pss_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pss_out_if;
  logic               valid;
  logic               ready;
  pss_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/pss_classify.sv
module pss_classify (
  input  logic [pss_pkg::UNIT_BITS-1:0] unit_i,
  input  logic                          wide_i,
  output pss_pkg::unit_class_t          class_o
);

  logic [7:0] byte_w;
  logic       byte_ok;
  logic       wide_ok;

  assign byte_w  = unit_i[7:0];
  assign byte_ok = (byte_w >= pss_pkg::BYTE_LOW && byte_w <= pss_pkg::BYTE_HIGH)
                || byte_w == pss_pkg::BYTE_LF || byte_w == pss_pkg::BYTE_CR
                || byte_w == pss_pkg::BYTE_TAB;
  assign wide_ok = unit_i >= pss_pkg::WIDE_LOW && unit_i <= pss_pkg::WIDE_HIGH;

  always_comb begin
    if (wide_i) begin
      class_o.extend = wide_ok;
      class_o.ends   = (unit_i == '0);
    end else begin
      class_o.extend = byte_ok;
      class_o.ends   = !byte_ok;
    end
  end

endmodule

### hdl/pss_tracker.sv
module pss_tracker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  pss_pkg::in_item_t    item_i,
  input  pss_pkg::cfg_t        cfg_i,
  input  pss_pkg::unit_class_t class_i,
  output logic                 emit_o,
  output pss_pkg::out_item_t   result_o
);

  localparam int unsigned OB = pss_pkg::OFFSET_BITS;
  localparam int unsigned LB = pss_pkg::LENGTH_BITS;
  localparam int unsigned CW = LB + pss_pkg::MINLEN_BITS;
  localparam int unsigned RW = LB + pss_pkg::RLEN_BITS;
  localparam int unsigned SW = OB + pss_pkg::OFS_BITS;

  logic [OB-1:0] position_q, position_d;
  logic [OB-1:0] run_start_q, run_start_d;
  logic [LB-1:0] run_count_q, run_count_d;

  logic [OB-1:0] step;
  logic [LB-1:0] count_inc;
  logic [LB-1:0] count_new;
  logic [LB-1:0] close_cnt;
  logic [OB-1:0] start_new;
  logic [CW-1:0] need_w;
  logic [CW-1:0] close_w;
  logic [RW-1:0] len_w;
  logic [SW-1:0] ofs_w;

  // saturating increment
  assign count_inc = (run_count_q == '1) ? run_count_q : run_count_q + LB'(1);
  assign count_new = class_i.extend ? count_inc : (class_i.ends ? '0 : run_count_q);
  assign start_new = (class_i.extend && run_count_q == '0) ? position_q : run_start_q;
  assign step      = cfg_i.wide_mode ? OB'(2) : OB'(1);

  // a terminator closes the old run, otherwise end of image flushes the new one
  always_comb begin
    if (class_i.ends) begin
      close_cnt = run_count_q;
    end else if (item_i.last) begin
      close_cnt = count_new;
    end else begin
      close_cnt = '0;
    end
  end

  // zero min_length acts as one
  assign need_w  = (cfg_i.min_length == '0) ? CW'(1) : CW'(cfg_i.min_length);
  assign close_w = CW'(close_cnt);
  assign emit_o  = (close_cnt != '0) && (close_w >= need_w);

  assign len_w = RW'(close_cnt);
  assign ofs_w = SW'(start_new);
  assign result_o.start_offset = ofs_w[pss_pkg::OFS_BITS-1:0];
  assign result_o.run_length   = (len_w > RW'({pss_pkg::RLEN_BITS{1'b1}}))
                               ? {pss_pkg::RLEN_BITS{1'b1}}
                               : len_w[pss_pkg::RLEN_BITS-1:0];
  assign result_o.is_wide      = cfg_i.wide_mode;

  always_comb begin
    position_d  = position_q;
    run_start_d = run_start_q;
    run_count_d = run_count_q;
    if (accept_i) begin
      run_start_d = start_new;
      if (item_i.last) begin
        position_d  = '0;
        run_count_d = '0;
      end else begin
        position_d  = position_q + step;
        run_count_d = count_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= '0;
      run_start_q <= '0;
      run_count_q <= '0;
    end else begin
      position_q  <= position_d;
      run_start_q <= run_start_d;
      run_count_q <= run_count_d;
    end
  end

`ifndef ASSERT_OFF
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.last |=> position_q == '0 && run_count_q == '0)
    else $error("end of image did not clear scan state");
  a_ends_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && class_i.ends |=> run_count_q == '0)
    else $error("terminator left a run open");
  a_no_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && class_i.extend && !item_i.last |=> run_count_q != '0)
    else $error("run count wrapped to zero");
`endif

endmodule

### hdl/pss_outbuf.sv
module pss_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pss_pkg::out_item_t data_i,
  output logic               space_o,
  pss_out_if.source          out_o
);

  localparam logic [1:0] FULL = 2'd2;

  logic [1:0]         count_q, count_d;
  pss_pkg::out_item_t slot0_q, slot0_d;
  pss_pkg::out_item_t slot1_q, slot1_d;
  logic               pop;

  assign pop       = (count_q != '0) && out_o.ready;
  assign space_o   = (count_q != FULL);
  assign out_o.valid = (count_q != '0);
  assign out_o.data  = slot0_q;

  always_comb begin
    count_d = count_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    case (count_q)
      2'd0: begin
        if (push_i) begin
          slot0_d = data_i;
          count_d = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          slot0_d = data_i;
        end else if (push_i) begin
          slot1_d = data_i;
          count_d = FULL;
        end else if (pop) begin
          count_d = 2'd0;
        end
      end
      FULL: begin
        if (pop) begin
          slot0_d = slot1_q;
          count_d = 2'd1;
        end
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

`ifndef ASSERT_OFF
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != FULL)
    else $error("result pushed into full buffer");
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("buffer count out of range");
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd1 && pop && !push_i |=> count_q == '0)
    else $error("buffer did not drain");
  a_head_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == FULL && !pop |=> $stable(slot0_q) && count_q == FULL)
    else $error("stalled head result changed");
`endif

endmodule

### hdl/printable_string_scanner_core.sv
// channel   dir  payload                                  transaction when
// in_i      in   unit[15:0], last                         in_i.valid && in_i.ready
// out_o     out  start_offset[31:0], run_length[15:0],    out_o.valid && out_o.ready
//                is_wide
// cfg       in   cfg_idx_i, cfg_data_i[15:0]              cfg_we_i
//
// one unit per cycle while a result slot is free: classify, count and compare
// sit between the scan state registers and a two-entry result buffer
// a result appears on out_o the cycle after the unit that closes its run, behind
// any earlier result still waiting in the buffer
// in_i.ready drops only when both result slots hold untaken results
// rst_ni is asynchronous: scan state, buffer count and config registers reset,
// min_length to 4 and byte mode
module printable_string_scanner_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pss_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [pss_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  pss_in_if.sink                            in_i,
  pss_out_if.source                         out_o
);

  // configuration registers
  pss_pkg::cfg_t cfg_q, cfg_d;

  // scan datapath
  pss_pkg::unit_class_t unit_class;
  pss_pkg::out_item_t   result;
  logic                 emit;
  logic                 accept;
  logic                 space;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pss_pkg::cfg_idx_e'(cfg_idx_i))
        pss_pkg::CFG_MIN_LENGTH: cfg_d.min_length = cfg_data_i[pss_pkg::MINLEN_BITS-1:0];
        pss_pkg::CFG_WIDE_MODE:  cfg_d.wide_mode  = cfg_data_i[0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_length <= pss_pkg::MIN_LENGTH_RESET;
      cfg_q.wide_mode  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // take a unit whenever a result slot is free
  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  pss_classify u_classify (
    .unit_i  (in_i.data.unit),
    .wide_i  (cfg_q.wide_mode),
    .class_o (unit_class)
  );

  pss_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i.data),
    .cfg_i    (cfg_q),
    .class_i  (unit_class),
    .emit_o   (emit),
    .result_o (result)
  );

  // results wait here so scanning goes on while the consumer stalls
  pss_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && emit),
    .data_i  (result),
    .space_o (space),
    .out_o   (out_o)
  );

`ifndef ASSERT_OFF
  a_emit_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit |-> result.run_length != '0)
    else $error("zero length run reported");
  a_emit_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit && cfg_q.min_length != '0 |-> result.run_length >= cfg_q.min_length)
    else $error("short run reported");
  a_result_seen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit |=> out_o.valid)
    else $error("reported run not presented");
`endif

endmodule

### sim/printable_string_scanner_core_tb.sv
module printable_string_scanner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [pss_pkg::CFG_IDX_BITS-1:0]  cfg_idx;
  logic [pss_pkg::CFG_DATA_BITS-1:0] cfg_data;

  pss_in_if  in_ch ();
  pss_out_if out_ch ();

  printable_string_scanner_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // units waiting to be sent, runs we expect the block to report
  pss_pkg::in_item_t  unit_queue[$];
  pss_pkg::out_item_t expected_runs[$];

  // our own copy of the scanner: config and scan state
  logic [pss_pkg::MINLEN_BITS-1:0] min_len_cfg;
  logic                            wide_cfg;
  logic [pss_pkg::OFS_BITS-1:0]    scan_pos;
  logic [pss_pkg::OFS_BITS-1:0]    run_origin;
  logic [pss_pkg::RLEN_BITS-1:0]   run_chars;

  int  mismatches;
  bit  in_taken;
  bit  out_taken;
  int  in_gap;
  int  out_stall;
  bit  in_calm;
  bit  out_calm;

  // clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the block hangs somewhere
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // idle length for one transaction; flips into and out of stretches with no idling
  function automatic int pause_len(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // close the open run; a run long enough becomes an expected result
  function automatic bit close_run(output pss_pkg::out_item_t r);
    logic [pss_pkg::MINLEN_BITS-1:0] need;
    bit                              hit;
    need = (min_len_cfg == '0) ? pss_pkg::MINLEN_BITS'(1) : min_len_cfg;
    hit  = (run_chars != '0) && (run_chars >= need);
    r.start_offset = run_origin;
    r.run_length   = run_chars;
    r.is_wide      = wide_cfg;
    run_chars = '0;
    return hit;
  endfunction

  // advance the scan state by one accepted unit
  function automatic void scan_unit(input logic [pss_pkg::UNIT_BITS-1:0] u,
                                    input logic lst);
    logic [7:0]         b;
    logic               grow;
    logic               stop;
    bit                 hit;
    pss_pkg::out_item_t r;
    hit = 1'b0;
    b   = u[7:0];
    if (wide_cfg) begin
      grow = (u >= pss_pkg::WIDE_LOW) && (u <= pss_pkg::WIDE_HIGH);
      stop = (u == '0);
    end else begin
      grow = ((b >= pss_pkg::BYTE_LOW) && (b <= pss_pkg::BYTE_HIGH))
             || b == pss_pkg::BYTE_LF || b == pss_pkg::BYTE_CR
             || b == pss_pkg::BYTE_TAB;
      stop = !grow;
    end
    if (grow) begin
      if (run_chars == '0) run_origin = scan_pos;
      if (run_chars != '1) run_chars = run_chars + 1'b1;
    end else if (stop) begin
      hit = close_run(r);
    end
    if (lst) begin
      if (!hit) hit = close_run(r);
      run_chars = '0;
      scan_pos  = '0;
    end else begin
      scan_pos = scan_pos + (wide_cfg ? pss_pkg::OFS_BITS'(2) : pss_pkg::OFS_BITS'(1));
    end
    if (hit) expected_runs.push_back(r);
  endfunction

  // input side: present queued units, holding each until it is taken
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (unit_queue.size() != 0) begin
        in_ch.data  <= unit_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_gap = pause_len(in_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side: stall for a random while after each result
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_stall = pause_len(out_calm);
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on every accepted unit, check every accepted result
  always @(posedge clk) begin
    pss_pkg::out_item_t want;
    pss_pkg::out_item_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        scan_unit(in_ch.data.unit, in_ch.data.last);
      end
      if (out_ch.valid && out_ch.ready) begin
        out_taken = 1'b1;
        got = out_ch.data;
        if (expected_runs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result offset %0d length %0d wide %0b",
                     $realtime, got.start_offset, got.run_length, got.is_wide);
        end else begin
          want = expected_runs.pop_front();
          if (got.start_offset !== want.start_offset || got.run_length !== want.run_length
              || got.is_wide !== want.is_wide) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch, expected offset %0d length %0d wide %0b,",
                        " got offset %0d length %0d wide %0b"},
                       $realtime, want.start_offset, want.run_length, want.is_wide,
                       got.start_offset, got.run_length, got.is_wide);
          end
        end
      end
    end
  end

  // register write while the block is idle; our copy follows
  task automatic set_reg(input pss_pkg::cfg_idx_e idx,
                         input logic [pss_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      pss_pkg::CFG_MIN_LENGTH: min_len_cfg = val;
      pss_pkg::CFG_WIDE_MODE:  wide_cfg    = val[0];
      default: ;
    endcase
  endtask

  task automatic push_unit(input logic [pss_pkg::UNIT_BITS-1:0] u, input logic lst);
    pss_pkg::in_item_t it;
    it.unit = u;
    it.last = lst;
    unit_queue.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_unit({8'h00, s[i]}, 1'b0);
  endtask

  // wait until everything sent has come back, then let the pipeline settle
  task automatic drain();
    do @(negedge clk);
    while (unit_queue.size() != 0 || in_ch.valid || expected_runs.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [pss_pkg::UNIT_BITS-1:0] text_unit(input bit wide_sel);
    logic [7:0] b;
    if (wide_sel) return 16'($urandom_range(pss_pkg::WIDE_LOW, pss_pkg::WIDE_HIGH));
    if ($urandom_range(0, 19) == 0) begin
      case ($urandom_range(0, 2))
        0:       b = pss_pkg::BYTE_TAB;
        1:       b = pss_pkg::BYTE_LF;
        default: b = pss_pkg::BYTE_CR;
      endcase
    end else begin
      b = 8'($urandom_range(pss_pkg::BYTE_LOW, pss_pkg::BYTE_HIGH));
    end
    // upper byte is don't-care in byte mode, so randomize it
    return {8'($urandom_range(0, 255)), b};
  endfunction

  // something that ends or interrupts a run, or plain noise
  function automatic logic [pss_pkg::UNIT_BITS-1:0] break_unit(input bit wide_sel);
    logic [7:0] b;
    int         r;
    r = $urandom_range(0, 9);
    if (r >= 7) return 16'($urandom_range(0, 16'hFFFF));
    if (wide_sel) begin
      if (r < 4) return '0;
      return $urandom_range(0, 1) ? 16'($urandom_range(1, 31))
                                  : 16'($urandom_range(16'hFF00, 16'hFFFF));
    end
    do b = 8'($urandom_range(0, 255));
    while ((b >= pss_pkg::BYTE_LOW && b <= pss_pkg::BYTE_HIGH) || b == pss_pkg::BYTE_LF
           || b == pss_pkg::BYTE_CR || b == pss_pkg::BYTE_TAB);
    return {8'($urandom_range(0, 255)), b};
  endfunction

  // runs of random text with random breaks; now and then an image ends
  task automatic run_phase(input logic [15:0] min_sel, input bit wide_sel, input int count);
    int n;
    int len;
    set_reg(pss_pkg::CFG_MIN_LENGTH, min_sel);
    set_reg(pss_pkg::CFG_WIDE_MODE, 16'(wide_sel));
    n = 0;
    while (n < count) begin
      len = $urandom_range(0, 12);
      repeat (len) begin
        push_unit(text_unit(wide_sel), $urandom_range(0, 39) == 0);
        n++;
      end
      push_unit(break_unit(wide_sel), $urandom_range(0, 39) == 0);
      n++;
    end
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = pss_pkg::CFG_MIN_LENGTH;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    mismatches   = 0;
    in_taken     = 1'b0;
    out_taken    = 1'b0;
    in_gap       = 0;
    out_stall    = 0;
    in_calm      = 1'b0;
    out_calm     = 1'b0;
    min_len_cfg  = pss_pkg::MIN_LENGTH_RESET;
    wide_cfg     = 1'b0;
    scan_pos     = '0;
    run_origin   = '0;
    run_chars    = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // byte mode with reset config, min length 4
    push_text("Test");
    push_unit(16'h0000, 1'b0);              // terminator closes a reportable run
    push_text("xy");
    push_unit(16'h00FF, 1'b0);              // too short, dropped
    push_unit(16'(pss_pkg::BYTE_TAB), 1'b0);
    push_unit(16'(pss_pkg::BYTE_LF), 1'b0);
    push_unit(16'(pss_pkg::BYTE_CR), 1'b0);
    push_unit(16'(pss_pkg::BYTE_LOW), 1'b0);
    push_unit(16'(pss_pkg::BYTE_HIGH), 1'b0);
    push_unit(16'h007F, 1'b0);              // just above the printable range
    push_unit(16'hFF41, 1'b0);              // upper byte ignored in byte mode
    push_unit(16'h8042, 1'b0);
    push_unit(16'h0143, 1'b0);
    push_unit(16'hFF44, 1'b1);              // end of image flushes the open run
    push_text("wxyz");
    push_unit(16'h0000, 1'b1);              // terminator on the last unit: one result only
    push_unit(16'h001F, 1'b0);
    push_unit(16'h0080, 1'b0);
    drain();

    // wide mode, every run reported
    set_reg(pss_pkg::CFG_MIN_LENGTH, 16'd1);
    set_reg(pss_pkg::CFG_WIDE_MODE, 16'd1);
    push_unit(16'h0041, 1'b0);
    push_unit(pss_pkg::WIDE_HIGH, 1'b0);
    push_unit(16'hFF00, 1'b0);              // skipped units do not end the run
    push_unit(16'h001F, 1'b0);
    push_unit(16'hFFFF, 1'b0);
    push_unit(16'h0000, 1'b0);
    push_unit(pss_pkg::WIDE_LOW, 1'b1);     // flush in wide mode
    push_unit(16'h0000, 1'b0);              // terminator with no open run
    push_unit(16'h0061, 1'b0);
    push_unit(16'h0062, 1'b0);              // run left open across the mode change
    drain();

    // switch back to bytes in the middle of a run
    set_reg(pss_pkg::CFG_WIDE_MODE, 16'd0);
    set_reg(pss_pkg::CFG_MIN_LENGTH, 16'd2);
    push_text("cd");
    push_unit(16'h0000, 1'b0);
    drain();

    // random phases across a spread of settings
    run_phase(16'd1, 1'b0, 80);
    run_phase(16'd0, 1'b1, 80);
    run_phase(16'd3, 1'b1, 80);
    run_phase(16'hFFFF, 1'b0, 40);
    run_phase(16'd6, 1'b0, 80);
    run_phase(16'd2, 1'b1, 80);
    run_phase(16'($urandom_range(1, 10)), 1'($urandom_range(0, 1)), 80);
    run_phase(16'd4, 1'b0, 50);

    repeat (10) @(negedge clk);
    while (expected_runs.size() != 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("missing result offset %0d length %0d wide %0b",
                 expected_runs[0].start_offset, expected_runs[0].run_length,
                 expected_runs[0].is_wide);
      void'(expected_runs.pop_front());
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
